@@ rtl/core/bst_pkg.sv @@
package bst_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 32;
    localparam int BOUND_W  = INDEX_W + 1;

    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 1;

    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + INDEX_W;
    localparam int LOW_LSB   = VAL_LSB + VALUE_W;
    localparam int HIGH_LSB  = LOW_LSB + INDEX_W;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SEARCH = 1'b1
    } func_t;

endpackage

@@ rtl/core/bst_ram.sv @@
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/binary_search_table.sv @@
// Sorted-table search engine.
// Slave channel (s_*): one transfer per item. s_tuser selects the item kind:
// a write stores s_tdata's value at entry_index and returns nothing; a search
// looks for the value as a key between low_bound and high_bound, inclusive.
// Master channel (m_*): one transfer per search. m_tuser is the found flag,
// m_tdata carries the slot holding the key (zero when not found).
// A write goes into the table as it is accepted and leaves the engine idle.
// A search alternates a table read state and a compare state per midpoint probe
// (at most 5 probes for 16 entries) and registers its result from the compare
// state on a hit, or from the read state once the range is empty on a miss; no
// new item is taken while that loop runs through the single-port-read table RAM.
// s_tready is high whenever no search is in progress, including while an
// earlier result waits on m_tready; a search that finishes while the output
// register is still full holds until the receiver takes the earlier result.
// Reset clears the control state and drops m_tvalid; the table contents are
// kept and read as undefined until written.
module binary_search_table
    import bst_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // entry_index[3:0], value[35:4], low_bound[39:36], high_bound[43:40], zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // func[0]
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // found_index[3:0], zero
    output logic [M_DATA_W-1:0] m_tdata,
    // found[0]
    output logic [M_USER_W-1:0] m_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam logic [IW:0] DEPTH_W = (IW+1)'(TABLE_DEPTH);
    localparam logic [BOUND_W-1:0] HI_LIMIT =
        (TABLE_DEPTH < (1 << INDEX_W)) ? BOUND_W'(TABLE_DEPTH) : BOUND_W'(1 << INDEX_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_COMPARE
    } state_t;

    state_t                     state_reg;
    logic [BOUND_W-1:0]         lo_reg;
    logic [BOUND_W-1:0]         hi_p1_reg;
    logic signed [VALUE_W-1:0]  key_reg;
    logic [INDEX_W-1:0]         mid_reg;
    logic                       m_tvalid_reg;
    logic                       found_reg;
    logic [INDEX_W-1:0]         found_index_reg;

    logic                       s_accept;
    func_t                      s_func;
    logic [INDEX_W-1:0]         s_entry_index;
    logic signed [VALUE_W-1:0]  s_value;
    logic [INDEX_W-1:0]         s_low_bound;
    logic [INDEX_W-1:0]         s_high_bound;
    logic [BOUND_W-1:0]         hi_p1_in;
    logic [BOUND_W-1:0]         hi_p1_clip;
    logic [IW-1:0]              wr_ext;
    logic                       wr_en;
    logic [BOUND_W-1:0]         probe_sum;
    logic [INDEX_W-1:0]         mid;
    logic [IW-1:0]              rd_ext;
    logic                       rd_en;
    logic [VALUE_W-1:0]         rd_data;
    logic signed [VALUE_W-1:0]  entry;
    logic                       range_open;
    logic                       out_free;
    logic                       result_load;

    assign s_func        = func_t'(s_tuser[0]);
    assign s_entry_index = s_tdata[IDX_LSB  +: INDEX_W];
    assign s_value       = s_tdata[VAL_LSB  +: VALUE_W];
    assign s_low_bound   = s_tdata[LOW_LSB  +: INDEX_W];
    assign s_high_bound  = s_tdata[HIGH_LSB +: INDEX_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // clip the upper bound to the last slot; kept as bound+1
    assign hi_p1_in   = BOUND_W'(s_high_bound) + BOUND_W'(1);
    assign hi_p1_clip = (hi_p1_in > HI_LIMIT) ? HI_LIMIT : hi_p1_in;

    assign wr_ext = IW'(s_entry_index);
    assign wr_en  = s_accept && (s_func == FUNC_WRITE) && ({1'b0, wr_ext} < DEPTH_W);

    assign range_open = lo_reg < hi_p1_reg;
    assign probe_sum  = lo_reg + hi_p1_reg - BOUND_W'(1);
    assign mid        = probe_sum[INDEX_W:1];
    assign rd_ext     = IW'(mid);
    assign rd_en      = (state_reg == ST_ISSUE) && range_open;
    assign entry      = rd_data;

    assign result_load = out_free &&
                         (((state_reg == ST_ISSUE) && !range_open) ||
                          ((state_reg == ST_COMPARE) && (entry == key_reg)));

    bst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_ext[AW-1:0]),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (rd_ext[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_func == FUNC_SEARCH)) begin
                        lo_reg    <= BOUND_W'(s_low_bound);
                        hi_p1_reg <= hi_p1_clip;
                        key_reg   <= s_value;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (range_open) begin
                        mid_reg   <= mid;
                        state_reg <= ST_COMPARE;
                    end else if (out_free) begin
                        found_reg       <= 1'b0;
                        found_index_reg <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                ST_COMPARE: begin
                    if (entry == key_reg) begin
                        if (out_free) begin
                            found_reg       <= 1'b1;
                            found_index_reg <= mid_reg;
                            state_reg       <= ST_IDLE;
                        end
                    end else if (entry > key_reg) begin
                        hi_p1_reg <= BOUND_W'(mid_reg);
                        state_reg <= ST_ISSUE;
                    end else begin
                        lo_reg    <= BOUND_W'(mid_reg) + BOUND_W'(1);
                        state_reg <= ST_ISSUE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(found_index_reg);
    assign m_tuser  = M_USER_W'(found_reg);

endmodule

@@ rtl/core/bst_check.sv @@
module bst_check
    import bst_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [S_USER_W-1:0] s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    logic s_xfer;
    logic is_search;

    assign s_xfer    = s_tvalid && s_tready;
    assign is_search = (s_tuser[0] == FUNC_SEARCH);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == 1'b0) |-> (m_tdata == '0))
        else $error("not-found result carries a nonzero slot");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !is_search && !m_tvalid |=> !m_tvalid)
        else $error("write transfer produced a result");

    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && is_search |=> !s_tready && !$rose(m_tvalid))
        else $error("search did not occupy the engine");

endmodule

bind binary_search_table bst_check u_bst_check (.*);
